// ===== rtl/signed_scaled_muldiv_floored_unit_defines.svh =====
// Assertion macros shared by the port checker.
`ifndef SIGNED_SCALED_MULDIV_FLOORED_UNIT_DEFINES_SVH
`define SIGNED_SCALED_MULDIV_FLOORED_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SSMDF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssmdf port check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SSMDF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssmdf port check failed");

`endif

// ===== rtl/ssmdf_pkg.sv =====
package ssmdf_pkg;

    localparam int ValW          = 64;
    localparam int MulW          = 32;
    localparam int DivW          = 32;
    localparam int QuotW         = 64;
    localparam int ProdW         = ValW + MulW;
    localparam int RemW          = DivW - 1;
    localparam int DivStepsPerStage = 2;
    localparam int DivStages     = ProdW / DivStepsPerStage;

    typedef struct packed {
        logic valid;
        logic err;
        logic neg;
    } ctl_t;

endpackage

// ===== rtl/ssmdf_mul.sv =====
module ssmdf_mul
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic signed [ssmdf_pkg::ValW-1:0]      dividend_value,
    input  logic signed [ssmdf_pkg::MulW-1:0]      multiplier,
    input  logic signed [ssmdf_pkg::DivW-1:0]      divisor,
    output ssmdf_pkg::ctl_t                        ctl_out,
    output logic        [ssmdf_pkg::ProdW-1:0]     prod_out,
    output logic        [ssmdf_pkg::RemW-1:0]      div_out
);

    ssmdf_pkg::ctl_t                      ctl_a_reg, ctl_a_next;
    ssmdf_pkg::ctl_t                      ctl_b_reg;
    ssmdf_pkg::ctl_t                      ctl_c_reg;
    logic [ssmdf_pkg::ValW-1:0]           amag_reg, amag_next;
    logic [ssmdf_pkg::MulW-1:0]           bmag_reg, bmag_next;
    logic [ssmdf_pkg::RemW-1:0]           d_a_reg, d_b_reg, d_c_reg;
    logic [ssmdf_pkg::ValW-1:0]           p0_reg, p0_next;
    logic [ssmdf_pkg::ValW-1:0]           p1_reg, p1_next;
    logic [ssmdf_pkg::ProdW-1:0]          prod_reg, prod_next;
    logic [ssmdf_pkg::ValW-1:0]           val_u;
    logic [ssmdf_pkg::MulW-1:0]           mul_u;
    logic [ssmdf_pkg::DivW-1:0]           div_u;

    always_comb
    begin
        val_u = $unsigned(dividend_value);
        mul_u = $unsigned(multiplier);
        div_u = $unsigned(divisor);
        ctl_a_next.valid = in_valid;
        ctl_a_next.err   = (div_u == '0) || div_u[ssmdf_pkg::DivW-1];
        ctl_a_next.neg   = val_u[ssmdf_pkg::ValW-1] ^ mul_u[ssmdf_pkg::MulW-1];
        amag_next = val_u[ssmdf_pkg::ValW-1] ? (~val_u + ssmdf_pkg::ValW'(1)) : val_u;
        bmag_next = mul_u[ssmdf_pkg::MulW-1] ? (~mul_u + ssmdf_pkg::MulW'(1)) : mul_u;
        p0_next = ssmdf_pkg::ValW'(amag_reg[ssmdf_pkg::MulW-1:0])
                  * ssmdf_pkg::ValW'(bmag_reg);
        p1_next = ssmdf_pkg::ValW'(amag_reg[ssmdf_pkg::ValW-1:ssmdf_pkg::MulW])
                  * ssmdf_pkg::ValW'(bmag_reg);
        prod_next = {p1_reg, {ssmdf_pkg::MulW{1'b0}}} + ssmdf_pkg::ProdW'(p0_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_a_reg <= '0;
            ctl_b_reg <= '0;
            ctl_c_reg <= '0;
        end
        else if (en)
        begin
            ctl_a_reg <= ctl_a_next;
            ctl_b_reg <= ctl_a_reg;
            ctl_c_reg <= ctl_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            amag_reg <= amag_next;
            bmag_reg <= bmag_next;
            d_a_reg  <= div_u[ssmdf_pkg::RemW-1:0];
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
            d_b_reg  <= d_a_reg;
            prod_reg <= prod_next;
            d_c_reg  <= d_b_reg;
        end
    end

    assign ctl_out  = ctl_c_reg;
    assign prod_out = prod_reg;
    assign div_out  = d_c_reg;

endmodule

// ===== rtl/ssmdf_div_stage.sv =====
module ssmdf_div_stage
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  ssmdf_pkg::ctl_t                   ctl_in,
    input  logic [ssmdf_pkg::ProdW-1:0]       work_in,
    input  logic [ssmdf_pkg::RemW-1:0]        rem_in,
    input  logic [ssmdf_pkg::RemW-1:0]        div_in,
    output ssmdf_pkg::ctl_t                   ctl_out,
    output logic [ssmdf_pkg::ProdW-1:0]       work_out,
    output logic [ssmdf_pkg::RemW-1:0]        rem_out,
    output logic [ssmdf_pkg::RemW-1:0]        div_out
);

    ssmdf_pkg::ctl_t                  ctl_reg;
    logic [ssmdf_pkg::ProdW-1:0]      work_reg, work_next;
    logic [ssmdf_pkg::RemW-1:0]       rem_reg, rem_next;
    logic [ssmdf_pkg::RemW-1:0]       div_reg;
    logic [ssmdf_pkg::RemW:0]         trial;
    logic [ssmdf_pkg::RemW+1:0]       diff;

    // Each step brings in the next dividend bit and shifts a quotient bit into the low end.
    always_comb
    begin
        rem_next  = rem_in;
        work_next = work_in;
        trial     = '0;
        diff      = '0;
        for (int i = 0; i < ssmdf_pkg::DivStepsPerStage; i++)
        begin
            trial     = {rem_next, work_next[ssmdf_pkg::ProdW-1]};
            diff      = {1'b0, trial} - {2'b00, div_in};
            work_next = {work_next[ssmdf_pkg::ProdW-2:0], 1'b0};
            if (!diff[ssmdf_pkg::RemW+1])
            begin
                rem_next     = diff[ssmdf_pkg::RemW-1:0];
                work_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[ssmdf_pkg::RemW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
            div_reg  <= div_in;
        end
    end

    assign ctl_out  = ctl_reg;
    assign work_out = work_reg;
    assign rem_out  = rem_reg;
    assign div_out  = div_reg;

endmodule

// ===== rtl/ssmdf_out.sv =====
module ssmdf_out
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ssmdf_pkg::ctl_t                      ctl_in,
    input  logic [ssmdf_pkg::ProdW-1:0]          work_in,
    input  logic [ssmdf_pkg::RemW-1:0]           rem_in,
    input  logic                                 out_ready,
    output logic                                 en,
    output logic                                 out_valid,
    output logic signed [ssmdf_pkg::QuotW-1:0]   quotient,
    output logic                                 divide_error
);

    logic                             out_valid_reg;
    logic                             skid_valid_reg;
    logic [ssmdf_pkg::QuotW-1:0]      out_q_reg, skid_q_reg;
    logic                             out_err_reg, skid_err_reg;
    logic [ssmdf_pkg::QuotW-1:0]      low;
    logic [ssmdf_pkg::QuotW-1:0]      fixed_q;
    logic                             rem_zero;
    logic                             take;

    // A negative result with a nonzero remainder rounds toward minus infinity.
    always_comb
    begin
        low      = work_in[ssmdf_pkg::QuotW-1:0];
        rem_zero = (rem_in == '0);
        if (ctl_in.err)
        begin
            fixed_q = '0;
        end
        else if (ctl_in.neg)
        begin
            fixed_q = ~low + ssmdf_pkg::QuotW'(rem_zero);
        end
        else
        begin
            fixed_q = low;
        end
        take = ctl_in.valid && !skid_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (take)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_ready)
            begin
                out_q_reg   <= skid_q_reg;
                out_err_reg <= skid_err_reg;
            end
        end
        else if (take)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_q_reg   <= fixed_q;
                skid_err_reg <= ctl_in.err;
            end
            else
            begin
                out_q_reg   <= fixed_q;
                out_err_reg <= ctl_in.err;
            end
        end
    end

    assign en           = !skid_valid_reg;
    assign out_valid    = out_valid_reg;
    assign quotient     = $signed(out_q_reg);
    assign divide_error = out_err_reg;

endmodule

// ===== rtl/signed_scaled_muldiv_floored_unit.sv =====
// Signed scaled multiply-divide with floored rounding.
// Input channel: in_valid/in_ready carry dividend_value, multiplier and divisor.
// Output channel: out_valid/out_ready carry quotient and divide_error.
// Each beat computes floor(dividend_value * multiplier / divisor) on a 96-bit
// product; only the low 64 quotient bits are returned. A divisor that is zero
// or negative returns divide_error high and a zero quotient.
// From the accepting edge to out_valid: three stages form the magnitudes and
// the product, 48 stages each retire two bits of the 96-bit restoring division,
// and one stage applies rounding and sign into the output register. One beat
// can enter every cycle while in_ready is high.
// Reset empties every stage; in_ready is high right after reset.
// When the receiver stalls, a second result is parked in a skid register and
// the whole pipeline then holds in place, with in_ready low, until the
// receiver takes the pending beat. No beat is lost or repeated.
module signed_scaled_muldiv_floored_unit
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [ssmdf_pkg::ValW-1:0]    dividend_value,
    input  logic signed [ssmdf_pkg::MulW-1:0]    multiplier,
    input  logic signed [ssmdf_pkg::DivW-1:0]    divisor,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [ssmdf_pkg::QuotW-1:0]   quotient,
    output logic                                 divide_error
);

    logic                             en;
    ssmdf_pkg::ctl_t                  div_ctl  [ssmdf_pkg::DivStages+1];
    logic [ssmdf_pkg::ProdW-1:0]      div_work [ssmdf_pkg::DivStages+1];
    logic [ssmdf_pkg::RemW-1:0]       div_rem  [ssmdf_pkg::DivStages+1];
    logic [ssmdf_pkg::RemW-1:0]       div_d    [ssmdf_pkg::DivStages+1];

    assign in_ready   = en;
    assign div_rem[0] = '0;

    ssmdf_mul u_mul
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_valid       (in_valid),
        .dividend_value (dividend_value),
        .multiplier     (multiplier),
        .divisor        (divisor),
        .ctl_out        (div_ctl[0]),
        .prod_out       (div_work[0]),
        .div_out        (div_d[0])
    );

    for (genvar g = 0; g < ssmdf_pkg::DivStages; g++)
    begin : g_div
        ssmdf_div_stage u_stage
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctl_in   (div_ctl[g]),
            .work_in  (div_work[g]),
            .rem_in   (div_rem[g]),
            .div_in   (div_d[g]),
            .ctl_out  (div_ctl[g+1]),
            .work_out (div_work[g+1]),
            .rem_out  (div_rem[g+1]),
            .div_out  (div_d[g+1])
        );
    end

    ssmdf_out u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl_in       (div_ctl[ssmdf_pkg::DivStages]),
        .work_in      (div_work[ssmdf_pkg::DivStages]),
        .rem_in       (div_rem[ssmdf_pkg::DivStages]),
        .out_ready    (out_ready),
        .en           (en),
        .out_valid    (out_valid),
        .quotient     (quotient),
        .divide_error (divide_error)
    );

endmodule

// ===== rtl/ssmdf_port_check.sv =====
`include "signed_scaled_muldiv_floored_unit_defines.svh"

module ssmdf_port_check
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic signed [ssmdf_pkg::QuotW-1:0]   quotient,
    input logic                                 divide_error
);

    `SSMDF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(quotient))
    `SSMDF_ASSERT_NEXT(a_err_hold, out_valid && !out_ready, $stable(divide_error))
    `SSMDF_ASSERT_SAME(a_err_zero, out_valid && divide_error, quotient == '0)
    `SSMDF_ASSERT_SAME(a_stall_has_beat, !in_ready, out_valid)
    `SSMDF_ASSERT_SAME(a_stall_cause, $fell(in_ready), $past(out_valid && !out_ready))

endmodule

bind signed_scaled_muldiv_floored_unit ssmdf_port_check u_port_check
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .quotient     (quotient),
    .divide_error (divide_error)
);
